>>> rtl/sspr_pkg.sv
// Shared types and constants for the servo status packet receiver.
// Used by sspr_core and servo_status_packet_receiver; no dependencies.
`default_nettype none

package sspr_pkg;

	localparam int TIMER_W = 24;

	typedef enum logic [1:0] {
		OP_ARM  = 2'd0,
		OP_BYTE = 2'd1,
		OP_TICK = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_RESPONSE = 2'd1,
		ST_CORRUPT     = 2'd2
	} status_t;

	localparam logic [1:0] CFG_SYNC_WAIT     = 2'd0;
	localparam logic [1:0] CFG_PER_BYTE_WAIT = 2'd1;
	localparam logic [1:0] CFG_CHECKSUM_WAIT = 2'd2;

	localparam logic [19:0] SYNC_WAIT_RST     = 20'd1000;
	localparam logic [15:0] PER_BYTE_WAIT_RST = 16'd100;
	localparam logic [15:0] CHECKSUM_WAIT_RST = 16'd2000;

	localparam logic [7:0] SYNC_MARK    = 8'hFF;
	localparam logic [7:0] HDR_LAST_POS = 8'd2;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	typedef struct packed {
		logic [19:0] sync_wait;
		logic [15:0] per_byte_wait;
		logic [15:0] checksum_wait;
	} cfg_t;

	typedef struct packed {
		logic        is_end;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  servo_id;
		logic [7:0]  device_error;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/servo_status_packet_receiver.sv
// Servo status packet receiver: config registers, framing core, output register.
// Depends on sspr_pkg and sspr_core.
// A result appears on m_axis in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle; the single output register is refilled in the
// cycle it drains, so only a stalled unread result holds off the input.
// Reset (arst_n low, async): receiver idle, timers and header fields zero,
// registers back to 1000 / 100 / 2000 ticks, no result pending.
`default_nettype none

module servo_status_packet_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
	                                         // [23:16] servo_id, [31:24] device_error,
	                                         // [33:32] status, rest zero
	output logic             m_axis_tuser,   // [0] is_end
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	sspr_pkg::cfg_t    cfg_q;
	sspr_pkg::result_t res;
	sspr_pkg::result_t res_q;
	logic              res_valid;
	logic              m_valid_q;
	logic              step;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign step          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_wait     <= sspr_pkg::SYNC_WAIT_RST;
			cfg_q.per_byte_wait <= sspr_pkg::PER_BYTE_WAIT_RST;
			cfg_q.checksum_wait <= sspr_pkg::CHECKSUM_WAIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sspr_pkg::CFG_SYNC_WAIT:     cfg_q.sync_wait     <= cfg_data;
				sspr_pkg::CFG_PER_BYTE_WAIT: cfg_q.per_byte_wait <= cfg_data[15:0];
				sspr_pkg::CFG_CHECKSUM_WAIT: cfg_q.checksum_wait <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	sspr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.opcode    (sspr_pkg::opcode_t'(s_axis_tuser)),
		.rx_byte   (s_axis_tdata),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.is_end;
	assign m_axis_tdata  = {6'd0, res_q.status, res_q.device_error, res_q.servo_id,
		res_q.payload_index, res_q.payload_byte};

endmodule

`default_nettype wire

>>> rtl/sspr_core.sv
// Packet framing state machine: sync hunt, header, payload, checksum, timeouts.
// Depends on sspr_pkg. Result is combinational; the top level registers it.
`default_nettype none

module sspr_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire sspr_pkg::opcode_t opcode,
	input  wire logic [7:0]        rx_byte,
	input  wire sspr_pkg::cfg_t    cfg,
	output logic                   res_valid,
	output sspr_pkg::result_t      res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECKSUM
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic                            ff_seen_q, ff_seen_d;
	logic [sspr_pkg::TIMER_W-1:0]    timer_q, timer_d;
	logic [7:0]                      bytes_left_q, bytes_left_d;
	logic [7:0]                      sum_q, sum_d;
	logic [7:0]                      id_q, id_d;
	logic [7:0]                      len_q, len_d;
	logic [7:0]                      err_q, err_d;
	logic [7:0]                      pos_q, pos_d;

	logic [7:0]                      payload_len;
	logic [sspr_pkg::TIMER_W-1:0]    hdr_budget;
	logic [sspr_pkg::TIMER_W-1:0]    pay_budget;

	assign payload_len = (len_q < sspr_pkg::LEN_OVERHEAD) ? 8'd0 : len_q - sspr_pkg::LEN_OVERHEAD;
	assign hdr_budget  = {7'd0, cfg.per_byte_wait, 1'b0} + {8'd0, cfg.per_byte_wait};
	assign pay_budget  = {8'd0, cfg.per_byte_wait} * {16'd0, payload_len};

	always_comb begin
		phase_d      = phase_q;
		ff_seen_d    = ff_seen_q;
		timer_d      = timer_q;
		bytes_left_d = bytes_left_q;
		sum_d        = sum_q;
		id_d         = id_q;
		len_d        = len_q;
		err_d        = err_q;
		pos_d        = pos_q;
		res_valid    = 1'b0;
		res.is_end        = 1'b0;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;
		res.servo_id      = id_q;
		res.device_error  = err_q;
		res.status        = sspr_pkg::ST_OK;
		if (step) begin
			if (opcode == sspr_pkg::OP_ARM) begin
				phase_d      = PH_SYNC;
				ff_seen_d    = 1'b0;
				timer_d      = {4'd0, cfg.sync_wait};
				bytes_left_d = 8'd0;
				sum_d        = 8'd0;
				id_d         = 8'd0;
				len_d        = 8'd0;
				err_d        = 8'd0;
				pos_d        = 8'd0;
			end else if (opcode == sspr_pkg::OP_TICK && phase_q != PH_IDLE) begin
				if (timer_q != '0) begin
					timer_d = timer_q - 1'b1;
				end else begin
					res_valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = (phase_q == PH_CHECKSUM) ? sspr_pkg::ST_CORRUPT
						: sspr_pkg::ST_NO_RESPONSE;
					phase_d    = PH_IDLE;
				end
			end else if (opcode == sspr_pkg::OP_BYTE) begin
				unique case (phase_q)
					PH_SYNC: begin
						if (rx_byte == sspr_pkg::SYNC_MARK) begin
							if (ff_seen_q) begin
								phase_d = PH_HEADER;
								timer_d = hdr_budget;
								pos_d   = 8'd0;
								sum_d   = 8'd0;
							end else begin
								ff_seen_d = 1'b1;
							end
						end else begin
							ff_seen_d = 1'b0;
						end
					end
					PH_HEADER: begin
						if (pos_q == 8'd0) begin
							id_d = rx_byte;
						end else if (pos_q == 8'd1) begin
							len_d = rx_byte;
						end else begin
							err_d = rx_byte;
						end
						sum_d = sum_q + rx_byte;
						pos_d = pos_q + 8'd1;
						if (pos_q == sspr_pkg::HDR_LAST_POS) begin
							pos_d = 8'd0;
							if (payload_len == 8'd0) begin
								phase_d = PH_CHECKSUM;
								timer_d = {8'd0, cfg.checksum_wait};
							end else begin
								phase_d      = PH_PAYLOAD;
								bytes_left_d = payload_len;
								timer_d      = pay_budget;
							end
						end
					end
					PH_PAYLOAD: begin
						res_valid         = 1'b1;
						res.payload_byte  = rx_byte;
						res.payload_index = pos_q;
						sum_d        = sum_q + rx_byte;
						pos_d        = pos_q + 8'd1;
						bytes_left_d = bytes_left_q - 8'd1;
						if (bytes_left_q == 8'd1) begin
							phase_d = PH_CHECKSUM;
							timer_d = {8'd0, cfg.checksum_wait};
						end
					end
					PH_CHECKSUM: begin
						res_valid  = 1'b1;
						res.is_end = 1'b1;
						res.status = (rx_byte == ~sum_q) ? sspr_pkg::ST_OK
							: sspr_pkg::ST_CORRUPT;
						phase_d    = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			ff_seen_q    <= 1'b0;
			timer_q      <= '0;
			bytes_left_q <= 8'd0;
			sum_q        <= 8'd0;
			id_q         <= 8'd0;
			len_q        <= 8'd0;
			err_q        <= 8'd0;
			pos_q        <= 8'd0;
		end else begin
			phase_q      <= phase_d;
			ff_seen_q    <= ff_seen_d;
			timer_q      <= timer_d;
			bytes_left_q <= bytes_left_d;
			sum_q        <= sum_d;
			id_q         <= id_d;
			len_q        <= len_d;
			err_q        <= err_d;
			pos_q        <= pos_d;
		end
	end

	a_arm_enters_sync: assert property (@(posedge clk) disable iff (!arst_n)
		step && opcode == sspr_pkg::OP_ARM |=> phase_q == PH_SYNC)
		else $error("arm did not restart the sync hunt");

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_end && opcode != sspr_pkg::OP_ARM |=> phase_q == PH_IDLE)
		else $error("end result without return to idle");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> pos_q <= sspr_pkg::HDR_LAST_POS)
		else $error("header position out of range");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_left_q != 8'd0)
		else $error("payload phase with no bytes left");

	a_payload_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_end |-> phase_q == PH_PAYLOAD && res.status == sspr_pkg::ST_OK)
		else $error("payload beat outside payload phase");

endmodule

`default_nettype wire
